// File: hw/rtl/rsa_pkg.sv
// rsa_pkg: shared types, codes and sizes of the rpn stack arithmetic unit
// no dependencies; imported by every module of the block
`default_nettype none

package rsa_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int WORD_W      = 32;
	localparam int DEPTH_W     = 5;
	localparam int DIVIDEND_W  = 48;
	localparam int DIVISOR_W   = 32;
	localparam int WIDE_W      = 49;

	// operation codes
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_POP  = 3'd1;
	localparam logic [2:0] OP_ADD  = 3'd2;
	localparam logic [2:0] OP_SUB  = 3'd3;
	localparam logic [2:0] OP_MUL  = 3'd4;
	localparam logic [2:0] OP_DIV  = 3'd5;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_UNDER = 3'd1;
	localparam logic [2:0] ST_OVER  = 3'd2;
	localparam logic [2:0] ST_DIVZ  = 3'd3;
	localparam logic [2:0] ST_SAT   = 3'd4;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_PUSH,
		CMD_POP1,
		CMD_POP2
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADDSUB,
		S_MUL,
		S_DIV,
		S_SAT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]               op;
		logic signed [WORD_W-1:0] value;
	} in_req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result;
		logic [2:0]               status;
		logic [DEPTH_W-1:0]       depth;
		logic [2:0]               last_error;
	} out_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/rsa_cell.sv
// rsa_cell: one stack entry; loads from the entry above on push, from one or
// two entries below on pop. depends on rsa_pkg
`default_nettype none

module rsa_cell
	import rsa_pkg::*;
(
	input  wire logic                     clk,
	input  wire cmd_t                     cmd,
	input  wire logic [WORD_W-1:0]        up_val,
	input  wire logic [WORD_W-1:0]        dn1_val,
	input  wire logic [WORD_W-1:0]        dn2_val,
	output logic [WORD_W-1:0]             val
);

	logic [WORD_W-1:0] val_q;

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_HOLD: val_q <= val_q;
			CMD_PUSH: val_q <= up_val;
			CMD_POP1: val_q <= dn1_val;
			CMD_POP2: val_q <= dn2_val;
			default:  val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

`default_nettype wire

// File: hw/rtl/rsa_div.sv
// rsa_div: restoring unsigned divider, one quotient bit per cycle
// depends on rsa_pkg
`default_nettype none

module rsa_div
	import rsa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       done,
	output logic [DIVIDEND_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

	logic [DIVIDEND_W-1:0] nq_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// shift in the next dividend bit and try the subtract
	assign rem_sh = {rem_q, nq_q[DIVIDEND_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			nq_q  <= {nq_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = nq_q;

endmodule

`default_nettype wire

// File: hw/rtl/rpn_stack_arithmetic_unit.sv
// rpn_stack_arithmetic_unit: Q16.16 operand stack with add, sub, mul, div
// depends on rsa_pkg, rsa_cell, rsa_div
//
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | in_data  (in_req_t: op, value)
// out     | output    | out_valid/out_ready | out_data (out_rsp_t)
//
// one request in flight; a new request is taken once the previous result sits
// in the output register, even if that result has not yet been taken.
// push, pop, errors and undefined codes go straight to the final state; add, sub
// and mul pass through saturation; divide waits for the divider's 48 quotient bits.
// the stack is a chain of DEPTH cells that shift on push and pop.
// reset clears depth, the sticky error and all control; entries need none.
// a stalled output holds its result; the core stalls in its final state.
`default_nettype none

module rpn_stack_arithmetic_unit
	import rsa_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_req_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_rsp_t      out_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic signed [WIDE_W-1:0] V_MAX = 49'sd2147483647;
	localparam logic signed [WIDE_W-1:0] V_MIN = -49'sd2147483648;

	state_t state_q, state_d;

	logic [CW-1:0]             count_q;
	logic [2:0]                op_q;
	logic signed [WORD_W-1:0]  a_q, b_q;
	logic                      neg_q;
	logic signed [WIDE_W-1:0]  v_q;
	logic [WORD_W-1:0]         res_q;
	logic [2:0]                status_q;
	logic [2:0]                last_err_q;
	logic                      out_valid_q;
	out_rsp_t                  out_q;

	logic                      accept;
	logic                      out_load;
	logic                      div_start;
	logic                      div_done;
	logic [DIVIDEND_W-1:0]     quot;
	cmd_t                      cmd;

	logic                      full, empty, two;
	logic [WORD_W-1:0]         simple_res;
	logic [2:0]                simple_st;
	logic [WORD_W-1:0]         a_mag, b_mag;
	logic signed [63:0]        prod;

	// stack chain, entry 0 is the top
	logic [WORD_W-1:0] ent [0:DEPTH+1];
	logic [WORD_W-1:0] up  [0:DEPTH-1];

	assign ent[DEPTH]   = '0;
	assign ent[DEPTH+1] = '0;
	assign up[0]        = in_data.value;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i > 0) begin : g_up
			assign up[i] = ent[i-1];
		end
		rsa_cell u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.up_val  (up[i]),
			.dn1_val (ent[i+1]),
			.dn2_val (ent[i+2]),
			.val     (ent[i])
		);
	end

	assign full   = count_q >= CW'(DEPTH);
	assign empty  = count_q == '0;
	assign two    = count_q >= CW'(2);
	assign accept = in_valid && in_ready;

	// result and status of requests that finish at acceptance
	always_comb begin
		simple_res = '0;
		simple_st  = ST_OK;
		unique case (in_data.op)
			OP_PUSH: begin
				simple_res = in_data.value;
				if (full) simple_st = ST_OVER;
			end
			OP_POP: begin
				if (empty) simple_st = ST_UNDER;
				else simple_res = ent[0];
			end
			OP_ADD, OP_SUB, OP_MUL: begin
				if (!two) simple_st = ST_UNDER;
			end
			OP_DIV: begin
				if (!two) simple_st = ST_UNDER;
				else if (ent[0] == '0) simple_st = ST_DIVZ;
			end
			default: simple_st = ST_OK;
		endcase
	end

	assign a_mag = ent[1][WORD_W-1] ? (~ent[1] + 32'd1) : ent[1];
	assign b_mag = ent[0][WORD_W-1] ? (~ent[0] + 32'd1) : ent[0];
	assign prod  = 64'(a_q) * 64'(b_q);

	rsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({a_mag, 16'h0000}),
		.divisor  (b_mag),
		.done     (div_done),
		.quotient (quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_FIN;
					if (two) begin
						unique case (in_data.op)
							OP_ADD, OP_SUB: state_d = S_ADDSUB;
							OP_MUL:         state_d = S_MUL;
							OP_DIV:         state_d = (ent[0] == '0) ? S_FIN : S_DIV;
							default:        state_d = S_FIN;
						endcase
					end
				end
			end
			S_ADDSUB: state_d = S_SAT;
			S_MUL:    state_d = S_SAT;
			S_DIV:    if (div_done) state_d = S_SAT;
			S_SAT:    state_d = S_FIN;
			S_FIN:    if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		out_load  = 1'b0;
		div_start = 1'b0;
		cmd       = CMD_HOLD;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_data.op)
						OP_PUSH: if (!full) cmd = CMD_PUSH;
						OP_POP:  if (!empty) cmd = CMD_POP1;
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (two) cmd = CMD_POP2;
						default: cmd = CMD_HOLD;
					endcase
					div_start = (in_data.op == OP_DIV) && two && (ent[0] != '0);
				end
			end
			S_FIN:   out_load = !out_valid_q || out_ready;
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			last_err_q  <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (cmd)
					CMD_PUSH: count_q <= count_q + CW'(1);
					CMD_POP1: count_q <= count_q - CW'(1);
					CMD_POP2: count_q <= count_q - CW'(2);
					default:  count_q <= count_q;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (status_q != ST_OK) last_err_q <= status_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= in_data.op;
					a_q      <= ent[1];
					b_q      <= ent[0];
					neg_q    <= ent[1][WORD_W-1] ^ ent[0][WORD_W-1];
					res_q    <= simple_res;
					status_q <= simple_st;
				end
			end
			S_ADDSUB: begin
				if (op_q == OP_SUB)
					v_q <= {{17{a_q[WORD_W-1]}}, a_q} - {{17{b_q[WORD_W-1]}}, b_q};
				else
					v_q <= {{17{a_q[WORD_W-1]}}, a_q} + {{17{b_q[WORD_W-1]}}, b_q};
			end
			// arithmetic shift of the product rounds toward minus infinity
			S_MUL: v_q <= {prod[63], prod[63:16]};
			S_DIV: begin
				if (div_done) v_q <= neg_q ? (~{1'b0, quot} + 49'd1) : {1'b0, quot};
			end
			S_SAT: begin
				if (v_q > V_MAX) begin
					res_q    <= 32'h7FFF_FFFF;
					status_q <= ST_SAT;
				end else if (v_q < V_MIN) begin
					res_q    <= 32'h8000_0000;
					status_q <= ST_SAT;
				end else begin
					res_q    <= v_q[WORD_W-1:0];
					status_q <= ST_OK;
				end
			end
			S_FIN: begin
				if (out_load) begin
					out_q.result     <= res_q;
					out_q.status     <= status_q;
					out_q.depth      <= DEPTH_W'(count_q);
					out_q.last_error <= (status_q != ST_OK) ? status_q : last_err_q;
				end
			end
			default: v_q <= v_q;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/rsa_checker.sv
// rsa_checker: port-level checks of the rpn stack arithmetic unit, with bind
// depends on rsa_pkg and the top level rpn_stack_arithmetic_unit
`default_nettype none

module rsa_checker
	import rsa_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire in_req_t  in_data,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire out_rsp_t out_data
);

	// a waiting request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("waiting request changed");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// sticky error follows every failing request
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.last_error == out_data.status)
		else $error("last_error does not track status");

	// underflow and divide by zero report a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_UNDER || out_data.status == ST_DIVZ)
		|-> out_data.result == '0)
		else $error("error result not zero");

	// saturation clamps to one of the two limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_SAT
		|-> out_data.result == 32'h7FFF_FFFF || out_data.result == 32'h8000_0000)
		else $error("saturated result not at a limit");

endmodule

bind rpn_stack_arithmetic_unit rsa_checker u_rsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// File: dv/tb_rpn_stack_arithmetic_unit.sv
`timescale 1ns / 100ps
// tb_rpn_stack_arithmetic_unit: self-checking bench for the q16.16 rpn stack unit
// depends on rsa_pkg and rpn_stack_arithmetic_unit; reads and writes no files

module tb_rpn_stack_arithmetic_unit;
	import rsa_pkg::*;

	localparam int STACK_DEPTH  = DEPTH_DEF;
	localparam int RANDOM_OPS   = 950;
	localparam int PAUSE_EVERY  = 300;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 80;
	localparam int DIR_ROWS_N   = 28;

	localparam logic [2:0] OP_UNDEF6 = 3'd6;
	localparam logic [2:0] OP_UNDEF7 = 3'd7;

	localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
	localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] value;
		logic        typed;
		logic [31:0] result;
		logic [2:0]  status;
		logic [4:0]  depth;
		logic [2:0]  last_error;
	} dir_row_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     out_ready = 1'b0;
	in_req_t  in_data   = '0;
	logic     in_ready;
	logic     out_valid;
	out_rsp_t out_data;

	// shadow of the operand stack, advanced once per accepted request
	logic signed [31:0] stack_vals [STACK_DEPTH];
	int unsigned        stack_count = 0;
	logic [2:0]         sticky      = ST_OK;

	out_rsp_t    answer_q [$];
	int          bad_fields = 0;
	int unsigned cycles     = 0;
	int          burst_left = 0;
	int          stall_mode = 0;
	int          stall_left = 0;
	logic [1:0]  phase      = '0;
	out_rsp_t    want;

	// typed rows carry a hand-written expected response; the rest are checked against rpn_execute
	dir_row_t dir_rows [DIR_ROWS_N] = '{
		'{OP_POP,    32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDER, 5'd0, ST_UNDER},
		'{OP_ADD,    32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDER, 5'd0, ST_UNDER},
		'{OP_UNDEF6, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK,    5'd0, ST_UNDER},
		'{OP_UNDEF7, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK,    5'd0, ST_UNDER},
		'{OP_PUSH,   32'h1234_5678, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_DIV,    32'h0000_0000, 1'b1, 32'h0000_0000, ST_UNDER, 5'd1, ST_UNDER},
		'{OP_POP,    32'h0000_0000, 1'b1, 32'h1234_5678, ST_OK,    5'd0, ST_UNDER},
		'{OP_PUSH,   32'h7fff_ffff, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_PUSH,   32'h7fff_ffff, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_ADD,    32'h0000_0000, 1'b1, 32'h7fff_ffff, ST_SAT,   5'd0, ST_SAT},
		'{OP_PUSH,   32'h8000_0000, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_PUSH,   32'h0000_0001, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_SUB,    32'h0000_0000, 1'b1, 32'h8000_0000, ST_SAT,   5'd0, ST_SAT},
		'{OP_PUSH,   32'h8000_0000, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_PUSH,   32'h8000_0000, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_MUL,    32'h0000_0000, 1'b1, 32'h7fff_ffff, ST_SAT,   5'd0, ST_SAT},
		'{OP_PUSH,   32'hffff_ffff, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_PUSH,   32'h0000_0001, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		// tiny negative product must round toward minus infinity
		'{OP_MUL,    32'h0000_0000, 1'b1, 32'hffff_ffff, ST_OK,    5'd0, ST_SAT},
		'{OP_PUSH,   32'h0005_0000, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_PUSH,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK,    5'd2, ST_SAT},
		'{OP_DIV,    32'h0000_0000, 1'b1, 32'h0000_0000, ST_DIVZ,  5'd0, ST_DIVZ},
		'{OP_PUSH,   32'h8000_0000, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_PUSH,   32'hffff_0000, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_DIV,    32'h0000_0000, 1'b1, 32'h7fff_ffff, ST_SAT,   5'd0, ST_SAT},
		'{OP_PUSH,   32'h0003_0000, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		'{OP_PUSH,   32'h0002_0000, 1'b0, 32'h0,         ST_OK,    5'd0, ST_OK},
		// lower entry over top: 3.0 / 2.0
		'{OP_DIV,    32'h0000_0000, 1'b1, 32'h0001_8000, ST_OK,    5'd0, ST_SAT}
	};

	rpn_stack_arithmetic_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic out_rsp_t rpn_execute(input in_req_t req);
		out_rsp_t           rsp;
		logic signed [63:0] lower;
		logic signed [63:0] upper;
		logic signed [63:0] wide;
		rsp.result = '0;
		rsp.status = ST_OK;
		case (req.op)
		OP_PUSH: begin
			rsp.result = req.value;
			if (stack_count >= STACK_DEPTH) begin
				rsp.status = ST_OVER;
			end else begin
				stack_vals[stack_count] = req.value;
				stack_count++;
			end
		end
		OP_POP: begin
			if (stack_count == 0) begin
				rsp.status = ST_UNDER;
			end else begin
				stack_count--;
				rsp.result = stack_vals[stack_count];
			end
		end
		OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
			if (stack_count < 2) begin
				rsp.status = ST_UNDER;
			end else begin
				upper = stack_vals[stack_count - 1];
				lower = stack_vals[stack_count - 2];
				stack_count -= 2;
				wide = '0;
				case (req.op)
				OP_ADD: wide = lower + upper;
				OP_SUB: wide = lower - upper;
				OP_MUL: wide = (lower * upper) >>> 16;
				default: begin
					if (upper == 0)
						rsp.status = ST_DIVZ;
					else
						wide = (lower <<< 16) / upper;
				end
				endcase
				if (rsp.status == ST_OK) begin
					if (wide > WORD_MAX) begin
						wide = WORD_MAX;
						rsp.status = ST_SAT;
					end else if (wide < WORD_MIN) begin
						wide = WORD_MIN;
						rsp.status = ST_SAT;
					end
					rsp.result = wide[31:0];
				end
			end
		end
		default: ;
		endcase
		if (rsp.status != ST_OK)
			sticky = rsp.status;
		rsp.depth = stack_count[4:0];
		rsp.last_error = sticky;
		return rsp;
	endfunction

	task automatic flag_field(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("mismatch %s: got %h, wanted %h, cycle %0d", what, got, exp_val, cycles);
		bad_fields++;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_req(input in_req_t req, input logic use_row, input out_rsp_t row_rsp);
		int       gap;
		out_rsp_t calc;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
				: $urandom_range(1, 20);
		end
		burst_left--;
		in_data  <= req;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		calc = rpn_execute(req);
		answer_q.push_back(use_row ? row_rsp : calc);
		@(negedge clk);
	endtask

	// receiver stall pattern: free run, coin flip, one in four, mostly stalled
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 150);
		end
		stall_left--;
		phase <= phase + 2'd1;
		case (stall_mode)
		0: out_ready <= 1'b1;
		1: out_ready <= ($urandom_range(0, 1) == 1);
		2: out_ready <= (phase == 2'd0);
		default: out_ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (answer_q.size() == 0) begin
				flag_field("result with no request pending", out_data.result, 32'h0);
			end else begin
				want = answer_q.pop_front();
				if (out_data.result !== want.result)
					flag_field("result", out_data.result, want.result);
				if (out_data.status !== want.status)
					flag_field("status", 32'(out_data.status), 32'(want.status));
				if (out_data.depth !== want.depth)
					flag_field("depth", 32'(out_data.depth), 32'(want.depth));
				if (out_data.last_error !== want.last_error)
					flag_field("last_error", 32'(out_data.last_error), 32'(want.last_error));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		in_req_t     req;
		out_rsp_t    row_rsp;
		int unsigned real_ops;
		int unsigned next_pause;
		int unsigned goal;
		int unsigned roll;
		logic [31:0] v;
		real_ops = 0;
		next_pause = PAUSE_EVERY;
		goal = 4;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS_N; i++) begin
			req.op = dir_rows[i].op;
			req.value = dir_rows[i].value;
			row_rsp.result = dir_rows[i].result;
			row_rsp.status = dir_rows[i].status;
			row_rsp.depth = dir_rows[i].depth;
			row_rsp.last_error = dir_rows[i].last_error;
			send_req(req, dir_rows[i].typed, row_rsp);
		end

		row_rsp = '0;
		while (real_ops < RANDOM_OPS) begin
			// hold off until the unit has drained every request
			if (real_ops >= next_pause) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (answer_q.size() != 0)
					@(negedge clk);
				next_pause += PAUSE_EVERY;
			end

			case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = (32'($urandom_range(0, 16)) - 32'd8) << 16;
			2: begin
				case ($urandom_range(0, 4))
				0: v = 32'h7fff_ffff;
				1: v = 32'h8000_0000;
				2: v = 32'h0000_0000;
				3: v = 32'hffff_ffff;
				default: v = 32'h0000_0001;
				endcase
			end
			3: v = 32'($urandom_range(0, 32'h3ffff)) - 32'h2_0000;
			default: v = (32'($urandom_range(0, 200)) - 32'd100) << 12;
			endcase
			req.value = v;

			if ($urandom_range(0, 99) < 4) begin
				req.op = ($urandom_range(0, 1) == 0) ? OP_UNDEF6 : OP_UNDEF7;
			end else begin
				real_ops++;
				// wander toward a target depth; past the top means overflow pushes
				if (stack_count == goal || $urandom_range(0, 49) == 0
						|| (stack_count == STACK_DEPTH && $urandom_range(0, 5) == 0)) begin
					goal = ($urandom_range(0, 9) == 0) ? STACK_DEPTH + $urandom_range(1, 3)
						: $urandom_range(0, STACK_DEPTH);
				end
				if (stack_count < goal && $urandom_range(0, 9) != 0) begin
					req.op = OP_PUSH;
				end else begin
					roll = $urandom_range(0, 9);
					if (roll < 2)
						req.op = OP_POP;
					else if (roll == 2)
						req.op = OP_PUSH;
					else
						req.op = 3'($urandom_range(OP_ADD, OP_DIV));
				end
			end
			send_req(req, 1'b0, row_rsp);
		end

		in_valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_fields == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
